### design/lbs_pkg.sv
package lbs_pkg;

  // Word command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // LED modes
  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_POWER_ON = 3'd1,
    MODE_ADV      = 3'd2,
    MODE_CONNECT  = 3'd3,
    MODE_SEND     = 3'd4,
    MODE_BATT     = 3'd5
  } mode_t;

  // Power-on sequence phases; the unused fourth code behaves as toggling
  typedef enum logic [1:0] {
    PH_INIT   = 2'd0,
    PH_HOLD   = 2'd1,
    PH_TOGGLE = 2'd2
  } phase_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_HOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADV_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADV_DURATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_PERIOD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_PERIOD  = 3'd5;

  // Configuration reset values (ms)
  localparam logic [15:0] RST_POWER_HOLD   = 16'd2000;
  localparam logic [15:0] RST_POWER_PERIOD = 16'd1000;
  localparam logic [15:0] RST_ADV_PERIOD   = 16'd500;
  localparam logic [15:0] RST_ADV_DURATION = 16'd5000;
  localparam logic [15:0] RST_SEND_PERIOD  = 16'd200;
  localparam logic [15:0] RST_BATT_PERIOD  = 16'd100;

  typedef struct packed {
    logic [15:0] power_on_hold_ms;
    logic [15:0] power_on_period_ms;
    logic [15:0] adv_period_ms;
    logic [15:0] adv_duration_ms;
    logic [15:0] send_period_ms;
    logic [15:0] batt_period_ms;
  } cfg_t;

  typedef struct packed {
    mode_t       cur_mode;
    phase_t      power_phase;
    logic [31:0] mode_start_ms;
    logic [31:0] last_toggle_ms;
    logic        blink_started;
    logic        led_reg;
  } state_t;

endpackage

### design/lbs_cfg_regs.sv
module lbs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data,
  output lbs_pkg::cfg_t                    cfg
);

  // Decode writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_on_hold_ms   <= lbs_pkg::RST_POWER_HOLD;
      cfg.power_on_period_ms <= lbs_pkg::RST_POWER_PERIOD;
      cfg.adv_period_ms      <= lbs_pkg::RST_ADV_PERIOD;
      cfg.adv_duration_ms    <= lbs_pkg::RST_ADV_DURATION;
      cfg.send_period_ms     <= lbs_pkg::RST_SEND_PERIOD;
      cfg.batt_period_ms     <= lbs_pkg::RST_BATT_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        lbs_pkg::CFG_POWER_HOLD:   cfg.power_on_hold_ms   <= cfg_data;
        lbs_pkg::CFG_POWER_PERIOD: cfg.power_on_period_ms <= cfg_data;
        lbs_pkg::CFG_ADV_PERIOD:   cfg.adv_period_ms      <= cfg_data;
        lbs_pkg::CFG_ADV_DURATION: cfg.adv_duration_ms    <= cfg_data;
        lbs_pkg::CFG_SEND_PERIOD:  cfg.send_period_ms     <= cfg_data;
        lbs_pkg::CFG_BATT_PERIOD:  cfg.batt_period_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### design/lbs_step.sv
module lbs_step (
  input  logic            cmd,
  input  logic [2:0]      mode_code,
  input  logic [31:0]     now_ms,
  input  lbs_pkg::cfg_t   cfg,
  input  lbs_pkg::state_t st,
  output lbs_pkg::state_t st_next
);

  logic [31:0] since_start;
  logic [31:0] since_toggle;
  logic [15:0] blink_period;
  logic        mode_ok;

  // Elapsed times, modulo 2^32
  assign since_start  = now_ms - st.mode_start_ms;
  assign since_toggle = now_ms - st.last_toggle_ms;
  assign mode_ok = (mode_code >= 3'(lbs_pkg::MODE_POWER_ON)) &&
                   (mode_code <= 3'(lbs_pkg::MODE_BATT));

  // Pick the toggle period of the blinking modes
  always_comb begin
    case (st.cur_mode)
      lbs_pkg::MODE_ADV:  blink_period = cfg.adv_period_ms;
      lbs_pkg::MODE_SEND: blink_period = cfg.send_period_ms;
      default:            blink_period = cfg.batt_period_ms;
    endcase
  end

  // Advance the pattern for one word
  always_comb begin
    st_next = st;
    if (cmd == lbs_pkg::CMD_SET) begin
      if (mode_ok) begin
        st_next.cur_mode       = lbs_pkg::mode_t'(mode_code);
        st_next.power_phase    = lbs_pkg::PH_INIT;
        st_next.mode_start_ms  = now_ms;
        st_next.last_toggle_ms = '0;
        st_next.blink_started  = 1'b0;
      end
    end else begin
      case (st.cur_mode)
        lbs_pkg::MODE_POWER_ON: begin
          case (st.power_phase)
            lbs_pkg::PH_INIT: begin
              st_next.led_reg     = 1'b1;
              st_next.power_phase = lbs_pkg::PH_HOLD;
            end
            lbs_pkg::PH_HOLD: begin
              if (since_start > {16'd0, cfg.power_on_hold_ms}) begin
                st_next.led_reg        = 1'b0;
                st_next.last_toggle_ms = now_ms;
                st_next.power_phase    = lbs_pkg::PH_TOGGLE;
              end
            end
            default: begin
              if (since_toggle > {16'd0, cfg.power_on_period_ms}) begin
                st_next.led_reg        = ~st.led_reg;
                st_next.last_toggle_ms = now_ms;
              end
            end
          endcase
        end
        lbs_pkg::MODE_CONNECT: st_next.led_reg = 1'b1;
        lbs_pkg::MODE_ADV, lbs_pkg::MODE_SEND, lbs_pkg::MODE_BATT: begin
          if (st.cur_mode == lbs_pkg::MODE_ADV &&
              since_start > {16'd0, cfg.adv_duration_ms}) begin
            // Advertising over: hold off, leave toggle timing alone
            st_next.led_reg = 1'b0;
          end else if (!st.blink_started) begin
            st_next.led_reg        = 1'b1;
            st_next.last_toggle_ms = now_ms;
            st_next.blink_started  = 1'b1;
          end else if (since_toggle > {16'd0, blink_period}) begin
            st_next.led_reg        = ~st.led_reg;
            st_next.last_toggle_ms = now_ms;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### design/led_status_blink_sequencer.sv
// Status LED blink sequencer for a single LED.
// Input channel (in_valid/in_ready): one word per item, either a mode set
// (cmd = 1, mode_code 1 to 5, now_ms) that restarts timing at now_ms, or a
// tick (cmd = 0, now_ms) that advances the current mode's blink pattern.
// Output channel (out_valid/out_ready): one word per input word carrying
// led_level, the LED drive after that item.
// Configuration port: cfg_we with cfg_index and cfg_data writes one of the
// six millisecond timing registers; write only while the block is idle.
// An accepted word is held in the input register, then its result moves
// to the output register. Throughput: one word per cycle unless the
// receiver stalls; the input register feeds the pattern logic and the
// output register; mode state is updated as each word moves to it.
// When the receiver stalls, the output word holds and the input register
// still takes one more word; ready drops only when both are full.
// Reset clears the valid flags of both registers, sets mode off and the
// LED lit, and loads the timing registers with their default values.
module led_status_blink_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [2:0]                    mode_code,
  input  logic [31:0]                   now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          led_level,
  input  logic                          cfg_we,
  input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  lbs_pkg::cfg_t   cfg;
  lbs_pkg::state_t st;
  lbs_pkg::state_t st_next;

  logic        s1_valid;
  logic        s1_cmd;
  logic [2:0]  s1_mode;
  logic [31:0] s1_now;
  logic        advance;

  lbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbs_step u_step (
    .cmd       (s1_cmd),
    .mode_code (s1_mode),
    .now_ms    (s1_now),
    .cfg       (cfg),
    .st        (st),
    .st_next   (st_next)
  );

  // Move the input word on when the output register is free or drains
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd  <= cmd;
      s1_mode <= mode_code;
      s1_now  <= now_ms;
    end
  end

  // Pattern state, updated once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      st.cur_mode       <= lbs_pkg::MODE_OFF;
      st.power_phase    <= lbs_pkg::PH_INIT;
      st.mode_start_ms  <= '0;
      st.last_toggle_ms <= '0;
      st.blink_started  <= 1'b0;
      st.led_reg        <= 1'b1;
    end else if (s1_valid && advance) begin
      st <= st_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      led_level <= st_next.led_reg;
    end
  end

endmodule

### design/lbs_checker.sv
module lbs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic led_level
);

  // Output channel empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(led_level))
    else $error("stalled output word changed");

  // After an accepted word passes the input register, the output register holds a valid word
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted word did not reach the output");

  // Empty output register never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind led_status_blink_sequencer lbs_checker u_lbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .led_level (led_level)
);

### tb/tb_led_status_blink_sequencer.sv
`timescale 1ns / 1ps

module tb_led_status_blink_sequencer;

  // Mode codes outside the defined set; a set to either is ignored
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  // Register indexes past the last timing register
  localparam logic [lbs_pkg::CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [lbs_pkg::CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;
  localparam logic LED_ON  = 1'b1;
  localparam logic LED_OFF = 1'b0;
  localparam int STALL_LIMIT = 1000;
  localparam int DIR_ROWS = 25;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          cmd = lbs_pkg::CMD_TICK;
  logic [2:0]                    mode_code = lbs_pkg::MODE_OFF;
  logic [31:0]                   now_ms = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          led_level;
  logic                          cfg_we = 1'b0;
  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index = lbs_pkg::CFG_POWER_HOLD;
  logic [15:0]                   cfg_data = '0;

  led_status_blink_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .mode_code (mode_code),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .led_level (led_level),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the timing registers and of the pattern state
  lbs_pkg::cfg_t   timing;
  lbs_pkg::mode_t  pat_mode;
  lbs_pkg::phase_t pat_phase;
  logic [31:0]     pat_start;
  logic [31:0]     pat_toggle_at;
  logic            pat_started;
  logic            pat_led;

  logic led_expect_q[$];
  int   mismatches = 0;
  int   tx_idle_pct = 8;
  int   rx_idle_pct = 8;
  int   rx_hold_cycles = 0;
  int   quiet_cycles = 0;
  logic [31:0] clock_ms;

  // Directed words; typed expectations only where obvious
  typedef struct packed {
    logic        c;
    logic [2:0]  m;
    logic [31:0] t;
    logic        typed;
    logic        led;
  } dir_row_t;

  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    // tick while off
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_0000, 1'b1, LED_ON},
    // set to off ignored
    '{lbs_pkg::CMD_SET,  lbs_pkg::MODE_OFF,      32'h0000_007B, 1'b1, LED_ON},
    '{lbs_pkg::CMD_SET,  MODE_SPARE6,            32'hFFFF_FFFF, 1'b1, LED_ON},
    '{lbs_pkg::CMD_SET,  MODE_SPARE7,            32'h0000_0000, 1'b1, LED_ON},
    // set keeps the level
    '{lbs_pkg::CMD_SET,  lbs_pkg::MODE_POWER_ON, 32'hFFFF_FF00, 1'b1, LED_ON},
    // first power-on tick
    '{lbs_pkg::CMD_TICK, MODE_SPARE7,            32'hFFFF_FF00, 1'b1, LED_ON},
    // hold exactly, wrapped
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_06D0, 1'b0, LED_ON},
    // hold passed
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_06D1, 1'b0, LED_ON},
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_0AB9, 1'b0, LED_ON},
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_0ABA, 1'b0, LED_ON},
    '{lbs_pkg::CMD_SET,  lbs_pkg::MODE_CONNECT,  32'h0000_0000, 1'b0, LED_ON},
    // connect is solid on
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_0005, 1'b1, LED_ON},
    '{lbs_pkg::CMD_SET,  lbs_pkg::MODE_ADV,      32'h0000_03E8, 1'b0, LED_ON},
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_03E8, 1'b0, LED_ON},
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_05DD, 1'b0, LED_ON},
    // advertising expired
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_1771, 1'b1, LED_OFF},
    '{lbs_pkg::CMD_SET,  lbs_pkg::MODE_SEND,     32'h0000_0000, 1'b0, LED_ON},
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_0000, 1'b0, LED_ON},
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_00C9, 1'b0, LED_ON},
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'hFFFF_FFFF, 1'b0, LED_ON},
    '{lbs_pkg::CMD_SET,  lbs_pkg::MODE_BATT,     32'hFFFF_FFFF, 1'b0, LED_ON},
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'hFFFF_FFFF, 1'b0, LED_ON},
    // wraps to 101 ms
    '{lbs_pkg::CMD_TICK, lbs_pkg::MODE_OFF,      32'h0000_0064, 1'b0, LED_ON},
    // restart same mode
    '{lbs_pkg::CMD_SET,  lbs_pkg::MODE_BATT,     32'hAAAA_AAAA, 1'b0, LED_ON},
    '{lbs_pkg::CMD_TICK, MODE_SPARE6,            32'h5555_5555, 1'b0, LED_ON}
  };

  // Blink step shared by advertising, send-data and battery warning
  function automatic void step_blink(input logic [31:0] t, input logic [15:0] period);
    logic [31:0] since_toggle;
    since_toggle = t - pat_toggle_at;
    if (!pat_started) begin
      pat_led = LED_ON;
      pat_toggle_at = t;
      pat_started = 1'b1;
    end else if (since_toggle > {16'd0, period}) begin
      pat_led = ~pat_led;
      pat_toggle_at = t;
    end
  endfunction

  // Advance the pattern by one word and return the LED level after it
  function automatic logic next_led_level(input logic c, input logic [2:0] m,
                                          input logic [31:0] t);
    logic [31:0] since_start;
    logic [31:0] since_toggle;
    since_start = t - pat_start;
    since_toggle = t - pat_toggle_at;
    if (c == lbs_pkg::CMD_SET) begin
      if (m >= lbs_pkg::MODE_POWER_ON && m <= lbs_pkg::MODE_BATT) begin
        pat_mode = lbs_pkg::mode_t'(m);
        pat_phase = lbs_pkg::PH_INIT;
        pat_start = t;
        pat_toggle_at = '0;
        pat_started = 1'b0;
      end
    end else begin
      case (pat_mode)
        lbs_pkg::MODE_POWER_ON: begin
          case (pat_phase)
            lbs_pkg::PH_INIT: begin
              pat_led = LED_ON;
              pat_phase = lbs_pkg::PH_HOLD;
            end
            lbs_pkg::PH_HOLD: begin
              if (since_start > {16'd0, timing.power_on_hold_ms}) begin
                pat_led = LED_OFF;
                pat_toggle_at = t;
                pat_phase = lbs_pkg::PH_TOGGLE;
              end
            end
            default: begin
              if (since_toggle > {16'd0, timing.power_on_period_ms}) begin
                pat_led = ~pat_led;
                pat_toggle_at = t;
              end
            end
          endcase
        end
        lbs_pkg::MODE_ADV: begin
          if (since_start > {16'd0, timing.adv_duration_ms}) pat_led = LED_OFF;
          else step_blink(t, timing.adv_period_ms);
        end
        lbs_pkg::MODE_CONNECT: pat_led = LED_ON;
        lbs_pkg::MODE_SEND:    step_blink(t, timing.send_period_ms);
        lbs_pkg::MODE_BATT:    step_blink(t, timing.batt_period_ms);
        default: ;
      endcase
    end
    return pat_led;
  endfunction

  // Offer one word, hold it until accepted, then queue its LED level
  task automatic send_word(input logic c, input logic [2:0] m, input logic [31:0] t,
                           input logic typed, input logic typed_led);
    logic lvl;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    mode_code <= m;
    now_ms <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lvl = next_led_level(c, m, t);
    led_expect_q.push_back(typed ? typed_led : lvl);
  endtask

  // Write one timing register and mirror it in the shadow copy
  task automatic write_timing(input logic [lbs_pkg::CFG_IDX_W-1:0] idx,
                              input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      lbs_pkg::CFG_POWER_HOLD:   timing.power_on_hold_ms = val;
      lbs_pkg::CFG_POWER_PERIOD: timing.power_on_period_ms = val;
      lbs_pkg::CFG_ADV_PERIOD:   timing.adv_period_ms = val;
      lbs_pkg::CFG_ADV_DURATION: timing.adv_duration_ms = val;
      lbs_pkg::CFG_SEND_PERIOD:  timing.send_period_ms = val;
      lbs_pkg::CFG_BATT_PERIOD:  timing.batt_period_ms = val;
      default: ;
    endcase
  endtask

  // Drain outstanding words, then reload every timing register
  task automatic reload_timing(input logic [15:0] hold, input logic [15:0] pw_period,
                               input logic [15:0] adv_period, input logic [15:0] adv_dur,
                               input logic [15:0] send_period, input logic [15:0] batt_period);
    in_valid <= 1'b0;
    @(posedge clk);
    while (led_expect_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_timing(lbs_pkg::CFG_POWER_HOLD, hold);
    write_timing(lbs_pkg::CFG_POWER_PERIOD, pw_period);
    write_timing(lbs_pkg::CFG_ADV_PERIOD, adv_period);
    write_timing(lbs_pkg::CFG_ADV_DURATION, adv_dur);
    write_timing(lbs_pkg::CFG_SEND_PERIOD, send_period);
    write_timing(lbs_pkg::CFG_BATT_PERIOD, batt_period);
    write_timing($urandom_range(0, 1) ? CFG_SPARE6 : CFG_SPARE7, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Mostly mode sets followed by runs of advancing ticks; some noise
  task automatic run_random(input int words, input int step_max);
    int done;
    int run_len;
    int pick;
    logic [2:0] junk_mode;
    done = 0;
    while (done < words) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        send_word(lbs_pkg::CMD_SET,
                  3'($urandom_range(lbs_pkg::MODE_POWER_ON, lbs_pkg::MODE_BATT)),
                  clock_ms, 1'b0, LED_ON);
        run_len = $urandom_range(2, 14);
        for (int k = 0; k < run_len; k++) begin
          clock_ms = clock_ms + 32'($urandom_range(0, step_max));
          send_word(lbs_pkg::CMD_TICK, 3'($urandom), clock_ms, 1'b0, LED_ON);
        end
        done += run_len + 1;
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0:       junk_mode = lbs_pkg::MODE_OFF;
          1:       junk_mode = MODE_SPARE6;
          default: junk_mode = MODE_SPARE7;
        endcase
        send_word(lbs_pkg::CMD_SET, junk_mode, $urandom, 1'b0, LED_ON);
      end else begin
        send_word(lbs_pkg::CMD_TICK, 3'($urandom), $urandom, 1'b0, LED_ON);
        done++;
      end
    end
  endtask

  // Stimulus and phase sequencing
  initial begin
    timing.power_on_hold_ms   = lbs_pkg::RST_POWER_HOLD;
    timing.power_on_period_ms = lbs_pkg::RST_POWER_PERIOD;
    timing.adv_period_ms      = lbs_pkg::RST_ADV_PERIOD;
    timing.adv_duration_ms    = lbs_pkg::RST_ADV_DURATION;
    timing.send_period_ms     = lbs_pkg::RST_SEND_PERIOD;
    timing.batt_period_ms     = lbs_pkg::RST_BATT_PERIOD;
    pat_mode = lbs_pkg::MODE_OFF;
    pat_phase = lbs_pkg::PH_INIT;
    pat_start = '0;
    pat_toggle_at = '0;
    pat_started = 1'b0;
    pat_led = LED_ON;
    clock_ms = $urandom;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].c, dir_rows[i].m, dir_rows[i].t, dir_rows[i].typed,
                dir_rows[i].led);
    end
    run_random(60, 3000);

    // All zero: every nonzero elapsed time passes
    reload_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(130, 3);

    // All ones, with no idling on either side
    reload_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(130, 70000);
    tx_idle_pct = 8;
    rx_idle_pct = 8;

    // Short periods; receiver holds off so the block backs up
    reload_timing(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
                  16'($urandom_range(1, 64)), 16'($urandom_range(1, 400)),
                  16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)));
    rx_hold_cycles = 60;
    run_random(130, 80);

    // Arbitrary register values
    reload_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    run_random(120, 70000);

    // Back to the power-up defaults
    reload_timing(lbs_pkg::RST_POWER_HOLD, lbs_pkg::RST_POWER_PERIOD,
                  lbs_pkg::RST_ADV_PERIOD, lbs_pkg::RST_ADV_DURATION,
                  lbs_pkg::RST_SEND_PERIOD, lbs_pkg::RST_BATT_PERIOD);
    run_random(120, 3000);

    in_valid <= 1'b0;
    @(posedge clk);
    while (led_expect_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        rx_hold_cycles = rx_hold_cycles - 1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Compare each accepted word against the oldest expected level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (led_expect_q.size() == 0) begin
        $display("%0t: unexpected word, led_level %b", $time, led_level);
        mismatches++;
      end else if (led_level !== led_expect_q[0]) begin
        $display("%0t: led_level expected %b actual %b", $time, led_expect_q[0],
                 led_level);
        mismatches++;
        void'(led_expect_q.pop_front());
      end else begin
        void'(led_expect_q.pop_front());
      end
    end
  end

  // Drop the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### files.f
design/lbs_pkg.sv
design/lbs_cfg_regs.sv
design/lbs_step.sv
design/led_status_blink_sequencer.sv
design/lbs_checker.sv
tb/tb_led_status_blink_sequencer.sv
